// ===== rtl/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Check that cons holds in the cycle after ante.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ===== rtl/deq_pkg.sv =====
// Package with types, codes and defaults for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_ERASE      = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;
  localparam logic [2:0] CMD_QUERY      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LOOK,
    S_DATA
  } deq_state_e;

endpackage

// ===== rtl/deq_ram.sv =====
// Element store: one write port, two registered read ports.
`timescale 1ns / 1ps

module deq_ram
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEQ_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_a_i,
  input  logic [AW-1:0]            raddr_a_i,
  output logic signed [DATA_W-1:0] rdata_a_o,
  input  logic                     re_b_i,
  input  logic [AW-1:0]            raddr_b_i,
  output logic signed [DATA_W-1:0] rdata_b_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | request   | in_valid_i, in_stall_o | command_i, value_i, position_i
//  out     | result    | out_valid_o, out_stall_i | status_o, count_o, is_empty_o,
//          |           |                        | front_value_o, back_value_o
//
// An accepted request goes through S_EXEC, S_LOOK and S_DATA to the output register,
// and S_DATA waits while that register holds a stalled result. in_stall_o stays high
// until S_IDLE is reached again. Erase at a middle position p adds a read and write
// pair per entry behind p: the tail moves down one entry per read and write pair.
// Elements sit in a circular buffer; the head pointer and count live in registers.
// Reset clears state, head, count and output valid; the memory needs no clearing pass.
// The next request is taken while a result still waits in the output register.
`timescale 1ns / 1ps

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [3:0]               position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [4:0]               count_o,
  output logic                     is_empty_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;

  deq_state_e state_q, state_d;

  logic [2:0]               cmd_q;
  logic signed [DATA_W-1:0] val_q;
  logic [3:0]               pos_q;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            held_q, held_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [1:0]               stat_q, stat_d;

  logic                     out_valid_q, out_valid_d;
  logic                     load_out;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;
  logic                     re_a, re_b;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic signed [DATA_W-1:0] rdata_a, rdata_b;

  logic                     full, empty;
  logic [XW-1:0]            held_x, pos_x;
  logic [AW:0]              last_off;

  // Map a logical offset from the head onto a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + off;
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full     = (held_q == CW'(DEPTH));
  assign empty    = (held_q == '0);
  assign held_x   = XW'(held_q);
  assign pos_x    = XW'(pos_q);
  assign last_off = empty ? '0 : (AW+1)'(held_q) - (AW+1)'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign load_out   = (state_q == S_DATA) && (!out_valid_q || !out_stall_i);

  // Sequence each request: execute, shift, look up ends, deliver
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    held_d      = held_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    we          = 1'b0;
    waddr       = head_q;
    wdata       = val_q;
    re_a        = 1'b0;
    re_b        = 1'b0;
    raddr_a     = head_q;
    raddr_b     = phys(head_q, last_off);
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_LOOK;
        stat_d  = ST_DONE;
        unique case (cmd_q)
          CMD_PUSH_FRONT: begin
            if (full) begin
              stat_d = ST_FULL;
            end else begin
              head_d = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
              we     = 1'b1;
              waddr  = head_d;
              held_d = held_q + CW'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              stat_d = ST_FULL;
            end else begin
              we     = 1'b1;
              waddr  = phys(head_q, (AW+1)'(held_q));
              held_d = held_q + CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              stat_d = ST_EMPTY;
            end else begin
              head_d = phys(head_q, (AW+1)'(1));
              held_d = held_q - CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              stat_d = ST_EMPTY;
            end else begin
              held_d = held_q - CW'(1);
            end
          end
          CMD_ERASE: begin
            if (pos_x >= held_x) begin
              stat_d = ST_RANGE;
            end else if (pos_q == '0) begin
              head_d = phys(head_q, (AW+1)'(1));
              held_d = held_q - CW'(1);
            end else if (pos_x + XW'(1) == held_x) begin
              held_d = held_q - CW'(1);
            end else begin
              idx_d   = AW'(pos_q);
              state_d = S_SHIFT_RD;
            end
          end
          CMD_CLEAR: begin
            held_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_SHIFT_RD: begin
        re_a    = 1'b1;
        raddr_a = phys(head_q, (AW+1)'(idx_q) + (AW+1)'(1));
        state_d = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = phys(head_q, (AW+1)'(idx_q));
        wdata = rdata_a;
        idx_d = idx_q + AW'(1);
        if ((CW+1)'(idx_q) + (CW+1)'(2) < (CW+1)'(held_q)) begin
          state_d = S_SHIFT_RD;
        end else begin
          held_d  = held_q - CW'(1);
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        state_d = S_DATA;
      end

      S_DATA: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and working values
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= command_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    idx_q  <= idx_d;
    stat_q <= stat_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o      <= stat_q;
      count_o       <= held_x[4:0];
      is_empty_o    <= empty;
      front_value_o <= empty ? '0 : rdata_a;
      back_value_o  <= empty ? '0 : rdata_b;
    end
  end

  assign out_valid_o = out_valid_q;

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

`include "double_ended_queue_assert.svh"

  `DEQ_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_head_bound, 1'b1, {1'b0, head_q} < (AW+1)'(DEPTH))
  `DEQ_ASSERT_NEXT(a_load_empty, load_out && empty, is_empty_o && front_value_o == '0 && back_value_o == '0)

endmodule
